// ----- rtl/core/alfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII LRC frame receiver package
// Character codes, field types and hex digit decode helpers.
// ----------------------------------------------------------------------------
package alfr_pkg;

   typedef logic [7:0] char_type;
   typedef logic [6:0] count7_type;

   localparam char_type   CHAR_COLON      = 8'h3A;
   localparam char_type   CHAR_CR         = 8'h0D;
   localparam char_type   CHAR_LF         = 8'h0A;
   localparam char_type   CHAR_ZERO       = 8'h30;
   localparam char_type   CHAR_A          = 8'h41;
   localparam char_type   CHAR_AT         = 8'h40;
   localparam char_type   DIGIT_TEN       = 8'd10;
   localparam count7_type MAX_CHARS_RESET = 7'd60;

   // Data digit: letters above '@' map from 'A' = 10, everything else from '0'.
   function automatic char_type data_digit(input char_type c);
      if (c > CHAR_AT) begin
         return c - CHAR_A + DIGIT_TEN;
      end
      return c - CHAR_ZERO;
   endfunction

   // Check digit: below ':' take c mod '0', else (c mod 'A') + 10.
   function automatic char_type check_digit(input char_type c);
      char_type m;
      if (c < CHAR_COLON) begin
         return (c >= CHAR_ZERO) ? c - CHAR_ZERO : c;
      end
      if (c >= 8'(3 * CHAR_A)) begin
         m = c - 8'(3 * CHAR_A);
      end else if (c >= 8'(2 * CHAR_A)) begin
         m = c - 8'(2 * CHAR_A);
      end else if (c >= CHAR_A) begin
         m = c - CHAR_A;
      end else begin
         m = c;
      end
      return m + DIGIT_TEN;
   endfunction

endpackage

// ----- rtl/core/ascii_lrc_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// ASCII LRC frame receiver
// Collects ':'-framed characters up to CR LF, then walks the character store
// with one read port and a single 8-bit accumulator to check the LRC.
// ----------------------------------------------------------------------------
// Ordinary characters are accepted one per cycle while the unit receives. The
// LF that ends a frame of n >= 5 characters stalls the input while the store
// is read for indexes 1 to n-3 through the registered read port and the result
// register is loaded; the status is valid once that register is loaded. A
// four-character frame skips the reads. A status held by rsp_stall also delays
// that load and extends the input stall. Reset returns to idle with max_chars 60.
module ascii_lrc_frame_receiver_unit #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  alfr_pkg::char_type  req_rx_char,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_frame_good,
   output alfr_pkg::count7_type rsp_frame_chars,
   output alfr_pkg::char_type  rsp_computed_check,
   output alfr_pkg::char_type  rsp_received_check,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  alfr_pkg::count7_type csr_max_chars
);
   import alfr_pkg::*;

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int IW = $clog2(BUFFER_DEPTH);
   localparam int MW = (CW > 7) ? CW : 7;

   typedef logic [CW-1:0] cnt_type;
   typedef enum logic [1:0] {ST_RECV, ST_WALK, ST_EMIT} state_type;

   state_type  state_ff;
   cnt_type    fill_ff, len_ff, issue_ff, tag_ff;
   logic       tag_vld_ff, short_ff;
   char_type   prev_ff, rd_data_ff, sum_ff, recv_ff;
   logic [3:0] hi_ff;
   count7_type max_chars_ff;
   logic       rsp_valid_ff, rsp_good_ff;
   count7_type rsp_chars_ff;
   char_type   rsp_comp_ff, rsp_recv_ff;

   char_type   store_mem [BUFFER_DEPTH];

   logic [MW-1:0] max_ext, depth_ext, lim, fill_ext;
   logic          accept, idle, full, store_en, frame_end, out_free;
   cnt_type       n_next, last_issue, data_end, chk_hi_pos;
   char_type      ddig, cdig, comp_val;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_RECV);
   assign csr_ready = 1'b1;

   assign max_ext   = MW'(max_chars_ff);
   assign depth_ext = MW'(BUFFER_DEPTH);
   assign lim       = (max_ext > depth_ext) ? depth_ext : max_ext;
   assign fill_ext  = MW'(fill_ff);
   assign idle      = (fill_ff == '0);
   assign full      = !idle && (fill_ext >= lim);
   assign n_next    = fill_ff + cnt_type'(1);
   assign store_en  = accept && ((idle && req_rx_char == CHAR_COLON) || (!idle && !full));
   assign frame_end = accept && !idle && !full && (req_rx_char == CHAR_LF)
                      && (prev_ff == CHAR_CR) && (n_next >= cnt_type'(4));

   assign last_issue = len_ff - cnt_type'(3);
   assign chk_hi_pos = len_ff - cnt_type'(4);
   assign data_end   = (len_ff - cnt_type'(5)) & ~cnt_type'(1);
   assign ddig       = data_digit(rd_data_ff);
   assign cdig       = check_digit(rd_data_ff);
   assign comp_val   = 8'd0 - sum_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[fill_ff[IW-1:0]] <= req_rx_char;
      end
      rd_data_ff <= store_mem[issue_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         fill_ff      <= '0;
         tag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            max_chars_ff <= csr_max_chars;
         end
         // emit reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         tag_vld_ff <= (state_ff == ST_WALK) && (issue_ff <= last_issue);
         tag_ff     <= issue_ff;

         case (state_ff)
            ST_RECV: begin
               if (accept) begin
                  if (idle) begin
                     if (req_rx_char == CHAR_COLON) begin
                        fill_ff <= cnt_type'(1);
                        prev_ff <= req_rx_char;
                     end
                  end else if (full) begin
                     // drop the partial frame
                     fill_ff <= '0;
                  end else if (frame_end) begin
                     fill_ff  <= '0;
                     len_ff   <= n_next;
                     sum_ff   <= '0;
                     recv_ff  <= '0;
                     issue_ff <= cnt_type'(1);
                     if (n_next == cnt_type'(4)) begin
                        short_ff <= 1'b1;
                        state_ff <= ST_EMIT;
                     end else begin
                        short_ff <= 1'b0;
                        state_ff <= ST_WALK;
                     end
                  end else begin
                     fill_ff <= n_next;
                     prev_ff <= req_rx_char;
                  end
               end
            end
            ST_WALK: begin
               if (issue_ff <= last_issue) begin
                  issue_ff <= issue_ff + cnt_type'(1);
               end
               if (tag_vld_ff) begin
                  if (tag_ff <= data_end) begin
                     if (tag_ff[0]) begin
                        hi_ff <= ddig[3:0];
                     end else begin
                        sum_ff <= sum_ff + {hi_ff, 4'h0} + ddig;
                     end
                  end else if (tag_ff == chk_hi_pos) begin
                     hi_ff <= cdig[3:0];
                  end else if (tag_ff == last_issue) begin
                     recv_ff  <= {hi_ff, 4'h0} + cdig;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_good_ff  <= !short_ff && (comp_val == recv_ff);
                  rsp_chars_ff <= 7'(len_ff);
                  rsp_comp_ff  <= comp_val;
                  rsp_recv_ff  <= recv_ff;
                  state_ff     <= ST_RECV;
               end
            end
            default: begin
               state_ff <= ST_RECV;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_good     = rsp_good_ff;
   assign rsp_frame_chars    = rsp_chars_ff;
   assign rsp_computed_check = rsp_comp_ff;
   assign rsp_received_check = rsp_recv_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      MW'(fill_ff) <= depth_ext)
      else $error("fill count beyond buffer depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> issue_ff <= last_issue + cnt_type'(1))
      else $error("store walk ran past the check characters");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside of emit");

   a_short_bad: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && short_ff |-> sum_ff == '0 && recv_ff == '0)
      else $error("short frame carries nonzero check values");

endmodule
